[rtl/vrpi_pkg.sv]
// ----------------------------------------------------------------------------
// vrpi_pkg
// shared types and constants for the vibration rms and peak indicator block
// ----------------------------------------------------------------------------
package vrpi_pkg;

    localparam int DIV_STEPS   = 64;
    localparam int ROOT_STEPS  = 32;
    localparam int N_DIV_LANES = 4;
    localparam int N_RT_LANES  = 5;
    localparam int PEAK_LANE   = 4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INVALID    = 2'd1;
    localparam logic [1:0] ST_NO_SAMPLES = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] duration;
        logic [31:0] count;
        logic [15:0] peak_x;
        logic [15:0] peak_y;
        logic [15:0] peak_z;
    } t_meta;

    typedef struct packed {
        t_meta                        meta;
        logic [31:0]                  divisor;
        logic [N_DIV_LANES-1:0][63:0] num;
        logic [N_DIV_LANES-1:0][31:0] rem;
        logic [63:0]                  peak_sq;
    } t_div_stage;

    typedef struct packed {
        t_meta                       meta;
        logic [N_RT_LANES-1:0][63:0] val;
        logic [N_RT_LANES-1:0][33:0] rem;
        logic [N_RT_LANES-1:0][31:0] root;
    } t_rt_stage;

endpackage

[rtl/vrpi_div_cell.sv]
// ----------------------------------------------------------------------------
// vrpi_div_cell
// one restoring division step on every lane, registered
// ----------------------------------------------------------------------------
module vrpi_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  vrpi_pkg::t_div_stage i_stage,
    output logic                o_valid,
    output vrpi_pkg::t_div_stage o_stage
);
    import vrpi_pkg::*;

    logic       r_valid;
    t_div_stage r_stage;
    t_div_stage n_stage;
    logic [32:0] w_part [N_DIV_LANES];

    always_comb begin
        n_stage = i_stage;
        for (int l = 0; l < N_DIV_LANES; l++) begin
            w_part[l] = {i_stage.rem[l], i_stage.num[l][63]};
            if (w_part[l] >= {1'b0, i_stage.divisor}) begin
                n_stage.rem[l] = 32'(w_part[l] - {1'b0, i_stage.divisor});
                n_stage.num[l] = {i_stage.num[l][62:0], 1'b1};
            end else begin
                n_stage.rem[l] = w_part[l][31:0];
                n_stage.num[l] = {i_stage.num[l][62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule

[rtl/vrpi_rt_cell.sv]
// ----------------------------------------------------------------------------
// vrpi_rt_cell
// one digit of a bitwise integer square root on every lane, registered
// ----------------------------------------------------------------------------
module vrpi_rt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  vrpi_pkg::t_rt_stage i_stage,
    output logic               o_valid,
    output vrpi_pkg::t_rt_stage o_stage
);
    import vrpi_pkg::*;

    logic      r_valid;
    t_rt_stage r_stage;
    t_rt_stage n_stage;
    logic [35:0] w_part  [N_RT_LANES];
    logic [35:0] w_trial [N_RT_LANES];

    always_comb begin
        n_stage = i_stage;
        for (int l = 0; l < N_RT_LANES; l++) begin
            w_part[l]  = {i_stage.rem[l], i_stage.val[l][63:62]};
            w_trial[l] = {2'b00, i_stage.root[l], 2'b01};
            n_stage.val[l] = {i_stage.val[l][61:0], 2'b00};
            if (w_part[l] >= w_trial[l]) begin
                n_stage.rem[l]  = 34'(w_part[l] - w_trial[l]);
                n_stage.root[l] = {i_stage.root[l][30:0], 1'b1};
            end else begin
                n_stage.rem[l]  = w_part[l][33:0];
                n_stage.root[l] = {i_stage.root[l][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule

[rtl/vibration_rms_peak_indicators.sv]
// ----------------------------------------------------------------------------
// vibration_rms_peak_indicators
// rms and peak indicators from the statistics of one acquisition window
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries one window's statistics per request;
// output channel o_valid/i_ready returns one result per request, in order.
// A request passes 64 division cells (sums over sample count) and then 32
// square root cells, then an output register: 97 register stages. One request
// can enter every cycle while the output is not held, so throughput is one per
// cycle unless a waiting result and a low i_ready hold the chain.
// The status (invalid window, no samples), saturated duration and pass-through
// peaks are worked out on entry; on an error status every other field is zero.
// Reset empties the chain and the output register. While a result waits and
// i_ready is low the whole chain holds and o_ready is low; the chain moves on
// in the cycle i_ready returns.
// ----------------------------------------------------------------------------
module vibration_rms_peak_indicators (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_start_ms,
    input  logic [63:0] i_end_ms,
    input  logic        i_stats_overflowed,
    input  logic [31:0] i_sample_count,
    input  logic [63:0] i_vector_square_sum,
    input  logic [63:0] i_vector_peak_square,
    input  logic [63:0] i_x_square_sum,
    input  logic [63:0] i_y_square_sum,
    input  logic [63:0] i_z_square_sum,
    input  logic [15:0] i_x_peak_abs,
    input  logic [15:0] i_y_peak_abs,
    input  logic [15:0] i_z_peak_abs,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_duration_ms,
    output logic [31:0] o_count_out,
    output logic [31:0] o_rms_vector,
    output logic [31:0] o_peak_vector,
    output logic [31:0] o_rms_x,
    output logic [31:0] o_rms_y,
    output logic [31:0] o_rms_z,
    output logic [15:0] o_peak_x,
    output logic [15:0] o_peak_y,
    output logic [15:0] o_peak_z
);
    import vrpi_pkg::*;

    logic       w_en;
    logic [63:0] w_diff;
    t_meta      w_meta;
    t_div_stage w_div   [DIV_STEPS+1];
    logic       w_div_v [DIV_STEPS+1];
    t_rt_stage  w_rt    [ROOT_STEPS+1];
    logic       w_rt_v  [ROOT_STEPS+1];
    t_rt_stage  w_last;
    logic       w_ok;

    logic        r_valid;
    logic [1:0]  r_status;
    logic [31:0] r_duration;
    logic [31:0] r_count;
    logic [N_RT_LANES-1:0][31:0] r_root;
    logic [15:0] r_px, r_py, r_pz;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;
    assign w_diff  = i_end_ms - i_start_ms;

    always_comb begin
        w_meta = '0;
        if (i_end_ms < i_start_ms || i_stats_overflowed) begin
            w_meta.status = ST_INVALID;
        end else if (i_sample_count == '0) begin
            w_meta.status = ST_NO_SAMPLES;
        end else begin
            w_meta.status   = ST_OK;
            w_meta.duration = (w_diff[63:32] != '0) ? 32'hFFFF_FFFF : w_diff[31:0];
            w_meta.count    = i_sample_count;
            w_meta.peak_x   = i_x_peak_abs;
            w_meta.peak_y   = i_y_peak_abs;
            w_meta.peak_z   = i_z_peak_abs;
        end
    end

    always_comb begin
        w_div_v[0]         = i_valid;
        w_div[0].meta      = w_meta;
        w_div[0].divisor   = i_sample_count;
        w_div[0].num[0]    = i_vector_square_sum;
        w_div[0].num[1]    = i_x_square_sum;
        w_div[0].num[2]    = i_y_square_sum;
        w_div[0].num[3]    = i_z_square_sum;
        w_div[0].rem       = '0;
        w_div[0].peak_sq   = i_vector_peak_square;
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        vrpi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_div_v[g]),
            .i_stage (w_div[g]),
            .o_valid (w_div_v[g+1]),
            .o_stage (w_div[g+1])
        );
    end

    always_comb begin
        w_rt_v[0]    = w_div_v[DIV_STEPS];
        w_rt[0].meta = w_div[DIV_STEPS].meta;
        for (int l = 0; l < N_DIV_LANES; l++) begin
            w_rt[0].val[l] = w_div[DIV_STEPS].num[l];
        end
        w_rt[0].val[PEAK_LANE] = w_div[DIV_STEPS].peak_sq;
        w_rt[0].rem  = '0;
        w_rt[0].root = '0;
    end

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_rt
        vrpi_rt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_rt_v[g]),
            .i_stage (w_rt[g]),
            .o_valid (w_rt_v[g+1]),
            .o_stage (w_rt[g+1])
        );
    end

    assign w_last = w_rt[ROOT_STEPS];
    assign w_ok   = (w_last.meta.status == ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_rt_v[ROOT_STEPS];
        end
        if (w_en) begin
            r_status   <= w_last.meta.status;
            r_duration <= w_last.meta.duration;
            r_count    <= w_last.meta.count;
            r_px       <= w_last.meta.peak_x;
            r_py       <= w_last.meta.peak_y;
            r_pz       <= w_last.meta.peak_z;
            r_root     <= w_ok ? w_last.root : '0;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_duration_ms = r_duration;
    assign o_count_out   = r_count;
    assign o_rms_vector  = r_root[0];
    assign o_rms_x       = r_root[1];
    assign o_rms_y       = r_root[2];
    assign o_rms_z       = r_root[3];
    assign o_peak_vector = r_root[PEAK_LANE];
    assign o_peak_x      = r_px;
    assign o_peak_y      = r_py;
    assign o_peak_z      = r_pz;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_rms_vector == '0 && o_peak_vector == '0
            && o_duration_ms == '0 && o_count_out == '0)
        else $error("error result carries non-zero fields");

    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_count_out != '0)
        else $error("ok result with zero sample count");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_INVALID
            || o_status == ST_NO_SAMPLES)
        else $error("unknown status code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("chain not held while result waits");
endmodule

[sim/tb_vibration_rms_peak_indicators.sv]
// ----------------------------------------------------------------------------
// tb_vibration_rms_peak_indicators
// self-checking bench for the vibration rms and peak indicator block: window
// statistics are driven on the request channel, each result is compared
// field by field against an in-bench predictor of status, duration, count,
// roots and peaks
module tb_vibration_rms_peak_indicators;
    timeunit 1ns;
    timeprecision 1ps;
    import vrpi_pkg::*;

    typedef struct {
        logic [63:0] start_ms, end_ms;
        logic        ovf;
        logic [31:0] cnt;
        logic [63:0] vsum, vpeak, xsum, ysum, zsum;
        logic [15:0] xpk, ypk, zpk;
    } t_window;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] duration, count, rms_v, peak_v, rms_x, rms_y, rms_z;
        logic [15:0] pk_x, pk_y, pk_z;
    } t_indicators;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_start_ms = '0, i_end_ms = '0;
    logic        i_stats_overflowed = 1'b0;
    logic [31:0] i_sample_count = '0;
    logic [63:0] i_vector_square_sum = '0, i_vector_peak_square = '0;
    logic [63:0] i_x_square_sum = '0, i_y_square_sum = '0, i_z_square_sum = '0;
    logic [15:0] i_x_peak_abs = '0, i_y_peak_abs = '0, i_z_peak_abs = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_duration_ms, o_count_out, o_rms_vector, o_peak_vector;
    logic [31:0] o_rms_x, o_rms_y, o_rms_z;
    logic [15:0] o_peak_x, o_peak_y, o_peak_z;

    t_indicators expected_q[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;
    int          hold_kick = 0;
    int          hold_seen = 0;

    vibration_rms_peak_indicators dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bit_val;
        root = '0;
        bit_val = 64'd1 << 62;
        while (bit_val > v) bit_val = bit_val >> 2;
        while (bit_val != 0) begin
            if (v >= root + bit_val) begin
                v = v - (root + bit_val);
                root = (root >> 1) + bit_val;
            end else begin
                root = root >> 1;
            end
            bit_val = bit_val >> 2;
        end
        return root[31:0];
    endfunction

    function automatic t_indicators predict_indicators(t_window w);
        t_indicators r;
        logic [63:0] dur;
        r = '{default: '0};
        if (w.end_ms < w.start_ms || w.ovf) begin
            r.status = ST_INVALID;
        end else if (w.cnt == 0) begin
            r.status = ST_NO_SAMPLES;
        end else begin
            dur = w.end_ms - w.start_ms;
            r.status   = ST_OK;
            r.duration = (dur > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dur[31:0];
            r.count    = w.cnt;
            r.rms_v    = floor_root(w.vsum / w.cnt);
            r.peak_v   = floor_root(w.vpeak);
            r.rms_x    = floor_root(w.xsum / w.cnt);
            r.rms_y    = floor_root(w.ysum / w.cnt);
            r.rms_z    = floor_root(w.zsum / w.cnt);
            r.pk_x     = w.xpk;
            r.pk_y     = w.ypk;
            r.pk_z     = w.zpk;
        end
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_sized();
        case ($urandom_range(3))
            0: return rand64();
            1: return rand64() >> $urandom_range(63);
            2: return {32'd0, $urandom};
            default: return 64'($urandom_range(1000));
        endcase
    endfunction

    task automatic send_window(t_window w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid              <= 1'b1;
        i_start_ms           <= w.start_ms;
        i_end_ms             <= w.end_ms;
        i_stats_overflowed   <= w.ovf;
        i_sample_count       <= w.cnt;
        i_vector_square_sum  <= w.vsum;
        i_vector_peak_square <= w.vpeak;
        i_x_square_sum       <= w.xsum;
        i_y_square_sum       <= w.ysum;
        i_z_square_sum       <= w.zsum;
        i_x_peak_abs         <= w.xpk;
        i_y_peak_abs         <= w.ypk;
        i_z_peak_abs         <= w.zpk;
        do @(posedge i_clk); while (!o_ready);
        expected_q.push_back(predict_indicators(w));
        @(negedge i_clk);
    endtask

    task automatic idle_sender();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_window random_window();
        t_window w;
        w.start_ms = rand_sized();
        case ($urandom_range(9))
            0: w.end_ms = rand64();
            1: w.end_ms = w.start_ms - 64'($urandom_range(1, 1000));
            default: w.end_ms = w.start_ms + rand_sized();
        endcase
        if (w.end_ms < w.start_ms && $urandom_range(1) == 1) w.end_ms = w.start_ms;
        w.ovf   = ($urandom_range(19) == 0);
        w.cnt   = ($urandom_range(19) == 0) ? 32'd0
                : ($urandom_range(1) ? $urandom : $urandom_range(1, 5000));
        w.vsum  = rand_sized();
        w.vpeak = rand_sized();
        w.xsum  = rand_sized();
        w.ysum  = rand_sized();
        w.zsum  = rand_sized();
        w.xpk   = 16'($urandom);
        w.ypk   = 16'($urandom);
        w.zpk   = 16'($urandom);
        return w;
    endfunction

    task automatic drain_results();
        int guard;
        guard = 0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
    endtask

    task automatic test_directed();
        t_window w;
        w = '{start_ms: 64'd100, end_ms: 64'd1100, ovf: 1'b0, cnt: 32'd10,
              vsum: 64'd1000, vpeak: 64'd400, xsum: 64'd90, ysum: 64'd160,
              zsum: 64'd250, xpk: 16'd3, ypk: 16'd4, zpk: 16'd5};
        send_window(w);
        w.ovf = 1'b1;
        send_window(w);
        w.ovf = 1'b0;
        w.end_ms = 64'd99;
        send_window(w);
        w.end_ms = 64'd100;
        w.cnt = 32'd0;
        send_window(w);
        w = '{start_ms: 64'd0, end_ms: '1, ovf: 1'b0, cnt: 32'd1,
              vsum: '1, vpeak: '1, xsum: '1, ysum: '1, zsum: '1,
              xpk: '1, ypk: '1, zpk: '1};
        send_window(w);
        w.cnt = '1;
        w.start_ms = '1;
        send_window(w);
        w.start_ms = 64'd5;
        w.end_ms = 64'd5 + 64'hFFFF_FFFF;
        send_window(w);
        w.end_ms = w.end_ms + 1;
        w.cnt = 32'h8000_0000;
        send_window(w);
        w = '{start_ms: '1, end_ms: 64'd0, ovf: 1'b1, cnt: '0,
              vsum: '0, vpeak: '0, xsum: '0, ysum: '0, zsum: '0,
              xpk: '0, ypk: '0, zpk: '0};
        send_window(w);
        w = '{start_ms: 64'd0, end_ms: 64'd0, ovf: 1'b0, cnt: 32'd1,
              vsum: '0, vpeak: '0, xsum: '0, ysum: '0, zsum: '0,
              xpk: '0, ypk: '0, zpk: '0};
        send_window(w);
        w.vpeak = 64'd15; w.xsum = 64'd16; w.ysum = 64'd24; w.zsum = 64'd25;
        send_window(w);
        w.cnt = 32'd3; w.vsum = 64'd2;
        send_window(w);
        idle_sender();
    endtask

    task automatic test_random(int n_items);
        repeat (n_items) send_window(random_window());
        idle_sender();
    endtask

    task automatic test_backpressure();
        hold_kick++;
        repeat (150) send_window(random_window());
        idle_sender();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 36;
        recv_idle_pct = 71;
        test_directed();
        test_random(200);
        send_idle_pct = 71;
        recv_idle_pct = 36;
        test_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(150);
        drain_results();
        repeat (120) @(negedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // receiver: random stalls, plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen   <= hold_kick;
            hold_cycles <= 400;
            i_ready     <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_indicators e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result, status %0d", o_status);
            end else begin
                e = expected_q.pop_front();
                if (o_status !== e.status || o_duration_ms !== e.duration
                    || o_count_out !== e.count || o_rms_vector !== e.rms_v
                    || o_peak_vector !== e.peak_v || o_rms_x !== e.rms_x
                    || o_rms_y !== e.rms_y || o_rms_z !== e.rms_z
                    || o_peak_x !== e.pk_x || o_peak_y !== e.pk_y
                    || o_peak_z !== e.pk_z) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp st %0d dur %0d cnt %0d rv %0d pv %0d",
                                 e.status, e.duration, e.count, e.rms_v, e.peak_v);
                        $display("         got st %0d dur %0d cnt %0d rv %0d pv %0d",
                                 o_status, o_duration_ms, o_count_out, o_rms_vector,
                                 o_peak_vector);
                        $display("  exp rx %0d ry %0d rz %0d px %0d py %0d pz %0d",
                                 e.rms_x, e.rms_y, e.rms_z, e.pk_x, e.pk_y, e.pk_z);
                        $display("  got rx %0d ry %0d rz %0d px %0d py %0d pz %0d",
                                 o_rms_x, o_rms_y, o_rms_z, o_peak_x, o_peak_y,
                                 o_peak_z);
                    end
                end
            end
        end
    end

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

[files.f]
rtl/vrpi_pkg.sv
rtl/vrpi_div_cell.sv
rtl/vrpi_rt_cell.sv
rtl/vibration_rms_peak_indicators.sv
sim/tb_vibration_rms_peak_indicators.sv
